### sv/mtpm_pkg.sv
// ----------------------------------------------------------------------------
// mtpm_pkg
// Shared types and constants for the multibit trie prefix match block.
// ----------------------------------------------------------------------------
`default_nettype none

package mtpm_pkg;

  localparam int ADDR_BITS = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_WALK,
    ST_INS_ROUTE,
    ST_LKP_WALK
  } state_t;

  typedef struct packed {
    logic        has_route;
    logic [5:0]  len;
    logic [15:0] hop;
  } route_t;

endpackage

`default_nettype wire

### sv/mtpm_ram.sv
// ----------------------------------------------------------------------------
// mtpm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mtpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/multibit_trie_prefix_match.sv
// ----------------------------------------------------------------------------
// multibit_trie_prefix_match
// Fixed-stride multibit trie for IPv4 longest prefix match: insert and lookup.
// ----------------------------------------------------------------------------
// Lookup: one child-table read per trie level, with the node route reads
// overlapped on the child reads.
// Insert: walks the levels, then a route read-modify-write keeps the longer prefix;
// when the last level allocates a fresh node the route is written directly.
// One item at a time; busy is high until the result strobe, which cannot stall.
// After reset a clearing pass over every child-table entry runs with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module multibit_trie_prefix_match #(
  parameter int STRIDE = 2,
  parameter int NODES  = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type,
  input  wire logic [31:0] address,
  input  wire logic [5:0]  prefix_len,
  input  wire logic [15:0] route_hop,
  output logic             done,
  output logic             hit,
  output logic [15:0]      next_hop,
  output logic             status
);

  localparam int NW     = $clog2(NODES);
  localparam int NUW    = $clog2(NODES + 1);
  localparam int SW     = NW + STRIDE;
  localparam int CDEPTH = NODES << STRIDE;
  localparam int RW     = $bits(mtpm_pkg::route_t);

  localparam logic [NUW-1:0] NODES_U  = NUW'(NODES);
  localparam logic [5:0]     STRIDE_W = 6'(STRIDE);
  localparam logic [6:0]     ABITS    = 7'(mtpm_pkg::ADDR_BITS);
  localparam logic [5:0]     LEN_MAX  = 6'(mtpm_pkg::ADDR_BITS);
  localparam logic [SW-1:0]  CLR_LAST = SW'(CDEPTH - 1);

  mtpm_pkg::state_t state, state_next;

  logic [5:0]        ofs, ofs_next;
  logic [31:0]       addr_sh, addr_sh_next;
  logic [STRIDE-1:0] addr_low, addr_low_next;
  logic [5:0]        len_q, len_q_next;
  logic [15:0]       hop_q, hop_q_next;
  logic [NW-1:0]     node_q, node_q_next;
  logic [SW-1:0]     slot_q, slot_q_next;
  logic [NUW-1:0]    nodes_used, nodes_used_next;
  logic [SW-1:0]     clr_cnt, clr_cnt_next;
  logic              child_pend, child_pend_next;
  logic              node_pend, node_pend_next;
  logic              hit_acc, hit_acc_next;
  logic [15:0]       hop_acc, hop_acc_next;
  logic              done_next, hit_next, status_next;
  logic [15:0]       next_hop_next;

  logic              c_we;
  logic [SW-1:0]     c_waddr, c_raddr;
  logic [NW-1:0]     c_wdata, c_rdata;
  logic              n_we;
  logic [NW-1:0]     n_waddr, n_raddr;
  mtpm_pkg::route_t  n_wdata, n_rdata;
  logic [RW-1:0]     n_rdata_raw;

  logic [5:0]        len_sat;
  logic [6:0]        ofs_end;
  logic [STRIDE-1:0] lvl_bits;
  logic              cd_ok, pool_full, ins_more, lkp_more, clr_last;

  mtpm_ram #(.WIDTH(NW), .DEPTH(CDEPTH)) u_child (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  mtpm_ram #(.WIDTH(RW), .DEPTH(NODES)) u_route (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata_raw)
  );

  assign n_rdata = mtpm_pkg::route_t'(n_rdata_raw);

  always_comb begin
    len_sat   = (prefix_len > LEN_MAX) ? LEN_MAX : prefix_len;
    ofs_end   = {1'b0, ofs} + {1'b0, STRIDE_W};
    lvl_bits  = (ofs_end <= ABITS) ? addr_sh[31 -: STRIDE] : addr_low;
    cd_ok     = (c_rdata != '0) && (NUW'(c_rdata) < NODES_U);
    pool_full = nodes_used >= NODES_U;
    ins_more  = ofs < len_q;
    lkp_more  = {1'b0, ofs} < ABITS;
    clr_last  = clr_cnt == CLR_LAST;
  end

  assign busy = state != mtpm_pkg::ST_IDLE;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mtpm_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = mtpm_pkg::ST_IDLE;
        end
      end
      mtpm_pkg::ST_IDLE: begin
        if (start) begin
          if (req_type == mtpm_pkg::REQ_LOOKUP) begin
            state_next = mtpm_pkg::ST_LKP_WALK;
          end else if (len_sat == '0) begin
            state_next = mtpm_pkg::ST_INS_ROUTE;
          end else begin
            state_next = mtpm_pkg::ST_INS_WALK;
          end
        end
      end
      mtpm_pkg::ST_INS_WALK: begin
        if (!cd_ok && pool_full) begin
          state_next = mtpm_pkg::ST_IDLE;
        end else if (!ins_more) begin
          state_next = cd_ok ? mtpm_pkg::ST_INS_ROUTE : mtpm_pkg::ST_IDLE;
        end
      end
      mtpm_pkg::ST_INS_ROUTE: begin
        state_next = mtpm_pkg::ST_IDLE;
      end
      mtpm_pkg::ST_LKP_WALK: begin
        if (!(child_pend && cd_ok)) begin
          state_next = mtpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mtpm_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and memory ports
  always_comb begin
    logic [NW-1:0] nd;
    logic          alloc;
    logic          h;
    logic [15:0]   hp;

    ofs_next        = ofs;
    addr_sh_next    = addr_sh;
    addr_low_next   = addr_low;
    len_q_next      = len_q;
    hop_q_next      = hop_q;
    node_q_next     = node_q;
    slot_q_next     = slot_q;
    nodes_used_next = nodes_used;
    clr_cnt_next    = clr_cnt;
    child_pend_next = child_pend;
    node_pend_next  = node_pend;
    hit_acc_next    = hit_acc;
    hop_acc_next    = hop_acc;
    done_next       = 1'b0;
    hit_next        = hit;
    next_hop_next   = next_hop;
    status_next     = status;

    c_we    = 1'b0;
    c_waddr = slot_q;
    c_wdata = nodes_used[NW-1:0];
    c_raddr = {node_q, lvl_bits};
    n_we    = 1'b0;
    n_waddr = node_q;
    n_wdata = '0;
    n_raddr = node_q;

    nd    = c_rdata;
    alloc = 1'b0;
    h     = hit_acc;
    hp    = hop_acc;

    case (state)
      mtpm_pkg::ST_CLEAR: begin
        c_we         = 1'b1;
        c_waddr      = clr_cnt;
        c_wdata      = '0;
        n_we         = 1'b1;
        n_waddr      = '0;
        n_wdata      = '0;
        clr_cnt_next = clr_cnt + 1'b1;
      end

      mtpm_pkg::ST_IDLE: begin
        if (start) begin
          addr_sh_next  = address << STRIDE;
          addr_low_next = address[STRIDE-1:0];
          len_q_next    = len_sat;
          hop_q_next    = route_hop;
          node_q_next   = '0;
          ofs_next      = STRIDE_W;
          c_raddr       = {{NW{1'b0}}, address[31 -: STRIDE]};
          slot_q_next   = {{NW{1'b0}}, address[31 -: STRIDE]};
          n_raddr       = '0;
          child_pend_next = 1'b1;
          node_pend_next  = 1'b0;
          hit_acc_next    = 1'b0;
          hop_acc_next    = '0;
        end
      end

      mtpm_pkg::ST_INS_WALK: begin
        if (!cd_ok && pool_full) begin
          done_next     = 1'b1;
          hit_next      = 1'b0;
          next_hop_next = '0;
          status_next   = mtpm_pkg::STATUS_FULL;
        end else begin
          if (!cd_ok) begin
            alloc           = 1'b1;
            nd              = nodes_used[NW-1:0];
            c_we            = 1'b1;
            nodes_used_next = nodes_used + 1'b1;
          end
          node_q_next = nd;
          n_raddr     = nd;
          n_waddr     = nd;
          if (ins_more) begin
            c_raddr      = {nd, lvl_bits};
            slot_q_next  = {nd, lvl_bits};
            ofs_next     = ofs + STRIDE_W;
            addr_sh_next = addr_sh << STRIDE;
            n_we         = alloc;
            n_wdata      = '0;
          end else if (alloc) begin
            // fresh node holds no route: write it straight away
            n_we          = 1'b1;
            n_wdata       = '{has_route: 1'b1, len: len_q, hop: hop_q};
            done_next     = 1'b1;
            hit_next      = 1'b0;
            next_hop_next = '0;
            status_next   = mtpm_pkg::STATUS_OK;
          end
        end
      end

      mtpm_pkg::ST_INS_ROUTE: begin
        n_waddr = node_q;
        n_wdata = '{has_route: 1'b1, len: len_q, hop: hop_q};
        n_we    = !n_rdata.has_route || (n_rdata.len < len_q);
        done_next     = 1'b1;
        hit_next      = 1'b0;
        next_hop_next = '0;
        status_next   = mtpm_pkg::STATUS_OK;
      end

      mtpm_pkg::ST_LKP_WALK: begin
        if (node_pend && n_rdata.has_route) begin
          h  = 1'b1;
          hp = n_rdata.hop;
        end
        hit_acc_next    = h;
        hop_acc_next    = hp;
        child_pend_next = 1'b0;
        node_pend_next  = 1'b0;
        if (child_pend && cd_ok) begin
          n_raddr        = c_rdata;
          node_pend_next = 1'b1;
          if (lkp_more) begin
            c_raddr         = {c_rdata, lvl_bits};
            child_pend_next = 1'b1;
            ofs_next        = ofs + STRIDE_W;
            addr_sh_next    = addr_sh << STRIDE;
          end
        end else begin
          done_next     = 1'b1;
          hit_next      = h;
          next_hop_next = hp;
          status_next   = mtpm_pkg::STATUS_OK;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mtpm_pkg::ST_CLEAR;
      nodes_used <= NUW'(1);
      clr_cnt    <= '0;
      child_pend <= 1'b0;
      node_pend  <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      nodes_used <= nodes_used_next;
      clr_cnt    <= clr_cnt_next;
      child_pend <= child_pend_next;
      node_pend  <= node_pend_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ofs      <= ofs_next;
    addr_sh  <= addr_sh_next;
    addr_low <= addr_low_next;
    len_q    <= len_q_next;
    hop_q    <= hop_q_next;
    node_q   <= node_q_next;
    slot_q   <= slot_q_next;
    hit_acc  <= hit_acc_next;
    hop_acc  <= hop_acc_next;
    hit      <= hit_next;
    next_hop <= next_hop_next;
    status   <= status_next;
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= NODES_U)
    else $error("node count past pool size");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == mtpm_pkg::ST_IDLE)
    else $error("result strobe while busy");

  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (!hit && next_hop == '0))
    else $error("pool full reported with a hit");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not raise busy");

endmodule

`default_nettype wire
